FILE: design/assert_macros.svh
// assertion macros for the design files (included by lsrr_core)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that also runs while reset is held
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/lsrr_pkg.sv
// types and constants for the led scan round robin block
package lsrr_pkg;

  localparam int unsigned LED_IDX_W = 5;
  localparam int unsigned PAT_W     = 32;
  localparam int unsigned COUNT_W   = 6;

  localparam logic [COUNT_W-1:0] LED_COUNT_RESET = 6'd32;

  localparam logic [2:0] KIND_WRITE  = 3'd0;
  localparam logic [2:0] KIND_SET    = 3'd1;
  localparam logic [2:0] KIND_CLEAR  = 3'd2;
  localparam logic [2:0] KIND_TOGGLE = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;
  localparam logic [2:0] KIND_TICK   = 3'd5;

  typedef struct packed {
    logic [2:0]       kind;
    logic [PAT_W-1:0] data;
    logic [PAT_W-1:0] mask;
  } lsrr_in_t;

  typedef struct packed {
    logic [PAT_W-1:0]     pattern;
    logic                 lit;
    logic [LED_IDX_W-1:0] lit_index;
    logic                 scanning;
  } lsrr_out_t;

endpackage

FILE: design/lsrr_next_sel.sv
// rotating search for the next set pattern bit after the current index
module lsrr_next_sel #(
  parameter int unsigned MAX_LEDS = 32
) (
  input  logic [MAX_LEDS-1:0]          cand_i,
  input  logic [lsrr_pkg::LED_IDX_W-1:0] cur_i,
  output logic                         found_o,
  output logic [lsrr_pkg::LED_IDX_W-1:0] sel_o
);
  import lsrr_pkg::*;

  logic [MAX_LEDS-1:0]  above;
  logic [LED_IDX_W-1:0] sel_above;
  logic [LED_IDX_W-1:0] sel_any;

  always_comb begin
    for (int j = 0; j < MAX_LEDS; j++) begin
      above[j] = cand_i[j] && (LED_IDX_W'(j) > cur_i);
    end
  end

  always_comb begin
    sel_above = '0;
    sel_any   = '0;
    for (int j = MAX_LEDS - 1; j >= 0; j--) begin
      if (above[j]) begin
        sel_above = LED_IDX_W'(j);
      end
      if (cand_i[j]) begin
        sel_any = LED_IDX_W'(j);
      end
    end
  end

  assign found_o = |cand_i;
  assign sel_o   = (|above) ? sel_above : sel_any;

endmodule

FILE: design/lsrr_core.sv
// pattern and scan state with the per-item update logic
`include "assert_macros.svh"

module lsrr_core #(
  parameter int unsigned MAX_LEDS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire_i,
  input  lsrr_pkg::lsrr_in_t           item_i,
  input  logic [lsrr_pkg::COUNT_W-1:0] led_count_i,
  output lsrr_pkg::lsrr_out_t          result_o
);
  import lsrr_pkg::*;

  localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_LEDS);

  logic [PAT_W-1:0]     pattern_r, pattern_nxt;
  logic [LED_IDX_W-1:0] cur_idx_r, cur_idx_nxt;
  logic                 running_r, running_nxt;
  logic                 driving_r, driving_nxt;

  logic [COUNT_W-1:0]   eff_count;
  logic [MAX_LEDS-1:0]  cand;
  logic                 found;
  logic [LED_IDX_W-1:0] sel;

  always_comb begin
    if (led_count_i == '0) begin
      eff_count = COUNT_W'(1);
    end else if (led_count_i > MaxCount) begin
      eff_count = MaxCount;
    end else begin
      eff_count = led_count_i;
    end
  end

  // only bits below the led count can be driven
  always_comb begin
    for (int j = 0; j < MAX_LEDS; j++) begin
      cand[j] = pattern_r[j] && (COUNT_W'(j) < eff_count);
    end
  end

  lsrr_next_sel #(
    .MAX_LEDS (MAX_LEDS)
  ) u_next_sel (
    .cand_i  (cand),
    .cur_i   (cur_idx_r),
    .found_o (found),
    .sel_o   (sel)
  );

  always_comb begin
    pattern_nxt = pattern_r;
    cur_idx_nxt = cur_idx_r;
    running_nxt = running_r;
    driving_nxt = driving_r;
    if (fire_i) begin
      unique case (item_i.kind)
        KIND_WRITE: begin
          pattern_nxt = (pattern_r & ~item_i.mask) | (item_i.data & item_i.mask);
          running_nxt = running_r || (pattern_nxt != '0);
        end
        KIND_SET: begin
          pattern_nxt = pattern_r | item_i.mask;
          running_nxt = running_r || (pattern_nxt != '0);
        end
        KIND_CLEAR: begin
          pattern_nxt = pattern_r & ~item_i.mask;
        end
        KIND_TOGGLE: begin
          pattern_nxt = pattern_r ^ item_i.mask;
          running_nxt = running_r || (pattern_nxt != '0);
        end
        KIND_TICK: begin
          if (running_r) begin
            driving_nxt = 1'b0;
            if (pattern_r == '0) begin
              running_nxt = 1'b0;
            end else if (found) begin
              cur_idx_nxt = sel;
              driving_nxt = 1'b1;
            end else begin
              running_nxt = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      cur_idx_r <= '0;
      running_r <= 1'b0;
      driving_r <= 1'b0;
    end else begin
      pattern_r <= pattern_nxt;
      cur_idx_r <= cur_idx_nxt;
      running_r <= running_nxt;
      driving_r <= driving_nxt;
    end
  end

  always_comb begin
    result_o.pattern   = pattern_nxt;
    result_o.lit       = driving_nxt;
    result_o.lit_index = driving_nxt ? cur_idx_nxt : '0;
    result_o.scanning  = running_nxt;
  end

  `ASSERT_CLK(a_drive_needs_run, driving_r |-> running_r,
              "led driven while scanning is stopped")
  `ASSERT_CLK(a_drive_on_tick, $rose(driving_r) |-> $past(fire_i && (item_i.kind == KIND_TICK)),
              "led driven without a scan tick")
  `ASSERT_CLK(a_hold_when_idle, !fire_i |=> ($stable(pattern_r) && $stable(running_r)),
              "state changed without an item")
  `ASSERT_CLK(a_index_moves_on_tick,
              (fire_i && (item_i.kind != KIND_TICK)) |=> $stable(cur_idx_r),
              "scan index moved on a non-tick item")

endmodule

FILE: design/led_scan_round_robin.sv
// top level of the round robin led scanner: handshake registers and count register
//
// Usage:
//   in channel (in_valid / in_ready / in_item) carries one access per item:
//   write, set, clear, toggle, read or scan tick. Every item gives exactly
//   one result on the out channel (out_valid / out_ready / out_item) with
//   the pattern, the lit led and the scanning flag after that item.
//   cfg_we / cfg_data write the led count; write it only while idle.
//   Flow: an item accepted into the input register is worked out by the
//   update logic once the result register can take it; the result is
//   registered there and drives out_item, with out_valid set.
//   Throughput: one item per cycle while the receiver does not stall; the input register
//   feeds the result register directly and the next-bit search is a single combinational
//   pass over the pattern.
//   Reset (rst_n low, synchronous) clears the pattern, stops scanning,
//   releases the led and sets the led count to 32.
//   When the receiver stalls, the result register holds its item and the
//   input register takes one more item before in_ready drops.
module led_scan_round_robin #(
  parameter int unsigned MAX_LEDS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lsrr_pkg::lsrr_in_t           in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lsrr_pkg::lsrr_out_t          out_item,
  input  logic                         cfg_we,
  input  logic [lsrr_pkg::COUNT_W-1:0] cfg_data
);
  import lsrr_pkg::*;

  logic               in_valid_r, in_valid_nxt;
  lsrr_in_t           in_item_r;
  logic               out_valid_r, out_valid_nxt;
  lsrr_out_t          out_item_r;
  logic [COUNT_W-1:0] led_count_r, led_count_nxt;

  logic      proceed;
  logic      fire;
  logic      in_take;
  lsrr_out_t result;

  assign proceed  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && proceed;
  assign in_ready = !in_valid_r || proceed;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_valid_nxt  = in_take || (in_valid_r && !fire);
    out_valid_nxt = fire || (out_valid_r && !out_ready);
    led_count_nxt = cfg_we ? cfg_data : led_count_r;
  end

  lsrr_core #(
    .MAX_LEDS (MAX_LEDS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire_i      (fire),
    .item_i      (in_item_r),
    .led_count_i (led_count_r),
    .result_o    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      led_count_r <= LED_COUNT_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      led_count_r <= led_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
